>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared same-cycle-implication and next-cycle-implication property checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/ntf_pkg.sv
// ----------------------------------------------------------------------------
// ntf_pkg
// Types, codes and constants shared by the number text formatter modules.
// ----------------------------------------------------------------------------
package ntf_pkg;

    localparam int VALUE_W = 54;
    localparam int CNT_W   = 6;
    localparam int KPOS_W  = 4;
    localparam int SYM_W   = 6;

    localparam logic [VALUE_W-1:0] GROUP_MIN = VALUE_W'(1000);

    // Operation codes; code three is unused and always fails.
    localparam logic [1:0] OP_KANJI = 2'd0;
    localparam logic [1:0] OP_ASCII = 2'd1;
    localparam logic [1:0] OP_WIDE  = 2'd2;

    localparam logic [SYM_W-1:0] SYM_ASCII_BASE = 6'd0;
    localparam logic [SYM_W-1:0] SYM_WIDE_BASE  = 6'd10;
    localparam logic [SYM_W-1:0] SYM_COMMA      = 6'd20;
    localparam logic [SYM_W-1:0] SYM_WIDE_COMMA = 6'd21;
    localparam logic [SYM_W-1:0] SYM_KJ_BASE    = 6'd21;
    localparam logic [SYM_W-1:0] SYM_PLACE_BASE = 6'd30;
    localparam logic [SYM_W-1:0] SYM_GROUP_BASE = 6'd33;
    localparam logic [SYM_W-1:0] SYM_CHO        = 6'd36;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT,
        ST_FAIL
    } t_state;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_DABBLE,
        CMD_SHIFT
    } t_cmd;

    typedef struct packed {
        logic [3:0] top;
        logic       low_zero;
    } t_dig_stat;

    typedef struct packed {
        logic             load;
        logic [SYM_W-1:0] symbol;
        logic             status;
        logic             last;
    } t_tok;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

>>> src/ntf_digit_unit.sv
// ----------------------------------------------------------------------------
// ntf_digit_unit
// Binary shift register and BCD register with per-digit add-3 correction and a shift step.
// ----------------------------------------------------------------------------
module ntf_digit_unit
    import ntf_pkg::*;
#(
    parameter int MAX_DIGITS = 16
) (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    output t_dig_stat          o_stat
);

    localparam int BCD_W = 4 * MAX_DIGITS;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [VALUE_W-1:0] n_bin;
    logic [BCD_W-1:0]   n_bcd;
    logic [BCD_W-1:0]   w_adj;

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                         : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        unique case (i_cmd)
            CMD_HOLD: begin
            end
            CMD_LOAD: begin
                n_bin = i_value;
                n_bcd = '0;
            end
            CMD_DABBLE: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            end
            CMD_SHIFT: begin
                n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_stat.top      = r_bcd[BCD_W-1 -: 4];
    assign o_stat.low_zero = (r_bcd[BCD_W-5:0] == '0);

endmodule

>>> src/ntf_ctrl.sv
// ----------------------------------------------------------------------------
// ntf_ctrl
// Sequencer: range check, conversion count, digit scan and token selection.
// ----------------------------------------------------------------------------
module ntf_ctrl
    import ntf_pkg::*;
#(
    parameter int MAX_DIGITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_op,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_out_free,
    input  t_dig_stat          i_stat,
    output logic               o_in_ready,
    output t_cmd               o_cmd,
    output t_tok               o_tok
);

    localparam int POS_BITS = $clog2(MAX_DIGITS);
    localparam logic [POS_BITS-1:0] POS_INIT  = POS_BITS'(MAX_DIGITS - 1);
    localparam logic [1:0]          MOD3_INIT = 2'((MAX_DIGITS - 1) % 3);
    localparam logic [VALUE_W-1:0]  LIMIT     = VALUE_W'(pow10(MAX_DIGITS));

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [1:0]          r_mod3, n_mod3;
    logic                r_ph, n_ph;
    logic                r_grp_nz, n_grp_nz;

    logic              w_fail;
    logic              w_kanji;
    logic [KPOS_W-1:0] w_kpos;
    logic [1:0]        w_q;
    logic [1:0]        w_g;
    logic              w_dnz;
    logic              w_tok1_v, w_tok2_v;
    logic [SYM_W-1:0]  w_tok1, w_tok2;
    logic              w_use2, w_emit, w_last;
    logic              w_conv_done;

    assign w_fail = (i_value >= LIMIT)
                 || ((i_op != OP_KANJI) && (i_op != OP_ASCII) && (i_op != OP_WIDE))
                 || ((i_op == OP_KANJI) && (i_value == '0))
                 || ((i_op != OP_KANJI) && (i_value < GROUP_MIN));

    assign w_kanji     = (r_op == OP_KANJI);
    assign w_kpos      = KPOS_W'(r_pos);
    assign w_q         = w_kpos[1:0];
    assign w_g         = w_kpos[3:2];
    assign w_dnz       = (i_stat.top != 4'd0);
    assign w_conv_done = (r_cnt == CNT_W'(VALUE_W - 1));

    // Up to two tokens per digit: a digit and a marker, or a digit and a comma.
    always_comb begin
        if (w_kanji) begin
            w_tok1 = SYM_KJ_BASE + SYM_W'(i_stat.top);
            if (w_q != 2'd0) begin
                w_tok1_v = (i_stat.top > 4'd1);
                w_tok2_v = w_dnz;
                w_tok2   = SYM_PLACE_BASE + SYM_W'(w_q);
            end else begin
                w_tok1_v = w_dnz;
                w_tok2_v = (w_g != 2'd0) && (r_grp_nz || w_dnz);
                w_tok2   = SYM_GROUP_BASE + SYM_W'(w_g);
            end
        end else begin
            w_tok1_v = 1'b1;
            w_tok1   = ((r_op == OP_WIDE) ? SYM_WIDE_BASE : SYM_ASCII_BASE)
                     + SYM_W'(i_stat.top);
            w_tok2_v = (r_pos != '0) && (r_mod3 == 2'd0);
            w_tok2   = (r_op == OP_WIDE) ? SYM_WIDE_COMMA : SYM_COMMA;
        end
    end

    // The marker phase is only entered when a second token exists.
    assign w_use2 = r_ph || !w_tok1_v;
    assign w_emit = (!r_ph && w_tok1_v) || w_tok2_v;
    always_comb begin
        if (w_use2) begin
            w_last = w_kanji && i_stat.low_zero;
        end else begin
            w_last = !w_tok2_v && (w_kanji ? i_stat.low_zero : (r_pos == '0));
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_fail ? ST_FAIL : ST_CONV;
                end
            end
            ST_CONV: begin
                if (w_conv_done) begin
                    n_state = w_kanji ? ST_EMIT : ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (w_dnz) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit && i_out_free && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FAIL: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op       = r_op;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_mod3     = r_mod3;
        n_ph       = r_ph;
        n_grp_nz   = r_grp_nz;
        o_cmd      = CMD_HOLD;
        o_in_ready = 1'b0;
        o_tok      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd    = CMD_LOAD;
                    n_op     = i_op;
                    n_cnt    = '0;
                    n_pos    = POS_INIT;
                    n_mod3   = MOD3_INIT;
                    n_ph     = 1'b0;
                    n_grp_nz = 1'b0;
                end
            end
            ST_CONV: begin
                o_cmd = CMD_DABBLE;
                n_cnt = r_cnt + CNT_W'(1);
            end
            ST_SKIP: begin
                if (!w_dnz) begin
                    o_cmd  = CMD_SHIFT;
                    n_pos  = r_pos - POS_BITS'(1);
                    n_mod3 = (r_mod3 == 2'd0) ? 2'd2 : r_mod3 - 2'd1;
                end
            end
            ST_EMIT: begin
                if (w_emit && i_out_free) begin
                    o_tok.load   = 1'b1;
                    o_tok.symbol = w_use2 ? w_tok2 : w_tok1;
                    o_tok.last   = w_last;
                end
                if (w_emit && i_out_free && !w_use2 && w_tok2_v) begin
                    n_ph = 1'b1;
                end else if (!w_emit || i_out_free) begin
                    o_cmd    = CMD_SHIFT;
                    n_pos    = r_pos - POS_BITS'(1);
                    n_mod3   = (r_mod3 == 2'd0) ? 2'd2 : r_mod3 - 2'd1;
                    n_ph     = 1'b0;
                    n_grp_nz = (w_q == 2'd0) ? 1'b0 : (r_grp_nz || w_dnz);
                end
            end
            ST_FAIL: begin
                if (i_out_free) begin
                    o_tok.load   = 1'b1;
                    o_tok.status = 1'b1;
                    o_tok.last   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op     <= n_op;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_mod3   <= n_mod3;
        r_ph     <= n_ph;
        r_grp_nz <= n_grp_nz;
    end

endmodule

>>> src/number_text_formatter_top.sv
// ----------------------------------------------------------------------------
// number_text_formatter_top
// Renders a binary number as kanji numerals or comma-grouped digit tokens.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                Word
//  s_axis   in   tdata: value; tuser: operation         one number
//  m_axis   out  tdata: symbol; tuser: status; tlast    one token
//
//  A number is taken in an idle cycle, then all 54 value bits pass through double-dabble conversion.
//  Grouped modes then skip leading zero digits to find the top digit of the value.
//  Each digit position gives at most two tokens: a digit and a marker or a comma.
//  A value with no rendering gives one unavailable word, via the fail state and output register.
//  Reset is synchronous, active low; a stalled output holds the sequencer until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module number_text_formatter_top
    import ntf_pkg::*;
#(
    parameter int MAX_DIGITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [53:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] symbol
    output logic [0:0]  m_axis_tuser,   // [0] status
    output logic        m_axis_tlast
);

    t_cmd      w_cmd;
    t_dig_stat w_stat;
    t_tok      w_tok;
    logic      w_out_free;

    logic             r_m_valid;
    logic [SYM_W-1:0] r_m_symbol;
    logic             r_m_status;
    logic             r_m_last;

    assign w_out_free = !r_m_valid || m_axis_tready;

    ntf_digit_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digit (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_value (s_axis_tdata[VALUE_W-1:0]),
        .o_stat  (w_stat)
    );

    ntf_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .i_value    (s_axis_tdata[VALUE_W-1:0]),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .o_tok      (w_tok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_tok.load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_tok.load) begin
            r_m_symbol <= w_tok.symbol;
            r_m_status <= w_tok.status;
            r_m_last   <= w_tok.last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_symbol};
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

    // An unavailable word is always a lone, final word with a zero symbol.
    `ASSERT_SAME(a_fail_word, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tlast && (m_axis_tdata == 8'd0))
    // The sequencer works on one number at a time.
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Symbols stay inside the token code range.
    `ASSERT_SAME(a_sym_range, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[5:0] <= SYM_CHO)
    // A word is only loaded when the output register can take it.
    `ASSERT_SAME(a_no_overrun, i_clk, i_rst_n, w_tok.load, w_out_free)

endmodule
